// ===== design/ksh_pkg.sv =====
// ----------------------------------------------------------------------------
// ksh_pkg
// Shared types and constants for the k-th smallest heap selector.
// ----------------------------------------------------------------------------
`default_nettype none

package ksh_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int POS_W        = IDX_W + 2;
    localparam int K_W          = 11;
    localparam int VAL_W        = 32;
    localparam int CMP_W        = (CNT_W > K_W) ? CNT_W : K_W;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } in_item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] kth_value;
        logic                    invalid;
        logic                    overflow;
    } result_t;

    typedef struct packed {
        logic                    we;
        logic [IDX_W-1:0]        waddr;
        logic signed [VAL_W-1:0] wdata;
        logic [IDX_W-1:0]        raddr;
    } mem_req_t;

endpackage

`default_nettype wire

// ===== design/ksh_ram.sv =====
// ----------------------------------------------------------------------------
// ksh_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ksh_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/ksh_seq.sv =====
// ----------------------------------------------------------------------------
// ksh_seq
// Load, heap build, k-1 extractions and result, over the heap RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module ksh_seq
    import ksh_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire in_item_t                data,
    input  wire logic [K_W-1:0]          k_rank,
    output mem_req_t                     mem_req,
    input  wire logic signed [VAL_W-1:0] rdata,
    output logic                         done,
    output result_t                      result
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_LOAD  = 4'd2;
    localparam logic [3:0] S_LATCH = 4'd3;
    localparam logic [3:0] S_RDR   = 4'd4;
    localparam logic [3:0] S_CMP   = 4'd5;
    localparam logic [3:0] S_PUT   = 4'd6;
    localparam logic [3:0] S_EXT   = 4'd7;
    localparam logic [3:0] S_ROOT  = 4'd8;
    localparam logic [3:0] S_EMIT  = 4'd9;

    logic [3:0]              state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    ovf_reg, ovf_next;
    logic [CNT_W-1:0]        size_reg, size_next;
    logic [K_W-1:0]          rem_reg, rem_next;
    logic [IDX_W-1:0]        i_reg, i_next;
    logic [IDX_W-1:0]        pos_reg, pos_next;
    logic [IDX_W-1:0]        ld_reg, ld_next;
    logic                    build_reg, build_next;
    logic signed [VAL_W-1:0] cur_reg, cur_next;
    logic signed [VAL_W-1:0] lval_reg, lval_next;
    logic                    done_reg, done_next;
    result_t                 result_reg, result_next;

    logic [POS_W-1:0]        lim;
    logic [POS_W-1:0]        l_pos, r_pos;
    logic                    bad;
    logic [CNT_W-1:0]        cnt_m1;
    logic                    take_l, take_r;
    logic [IDX_W-1:0]        best;
    logic signed [VAL_W-1:0] bval;
    logic [POS_W-1:0]        lb_pos;

    assign lim    = POS_W'(size_reg);
    assign l_pos  = {1'b0, pos_reg, 1'b1};
    assign r_pos  = {1'b0, pos_reg, 1'b0} + POS_W'(2);
    assign cnt_m1 = count_reg - CNT_W'(1);
    assign bad    = (k_rank == '0) || (CMP_W'(k_rank) > CMP_W'(count_reg));

    always_comb
    begin
        take_l = lval_reg < cur_reg;
        bval   = take_l ? lval_reg : cur_reg;
        best   = take_l ? l_pos[IDX_W-1:0] : pos_reg;
        take_r = (r_pos < lim) && (rdata < bval);
        if (take_r)
        begin
            bval = rdata;
            best = r_pos[IDX_W-1:0];
        end
        lb_pos = {1'b0, best, 1'b1};
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        size_next   = size_reg;
        rem_next    = rem_reg;
        i_next      = i_reg;
        pos_next    = pos_reg;
        ld_next     = ld_reg;
        build_next  = build_reg;
        cur_next    = cur_reg;
        lval_next   = lval_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        mem_req     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (count_reg == CNT_W'(MAX_ELEMENTS))
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = count_reg[IDX_W-1:0];
                        mem_req.wdata = data.value;
                        count_next    = count_reg + CNT_W'(1);
                    end
                    if (data.last)
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (bad)
                begin
                    done_next   = 1'b1;
                    result_next = '{kth_value: '0, invalid: 1'b1, overflow: ovf_reg};
                    count_next  = '0;
                    ovf_next    = 1'b0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    size_next  = count_reg;
                    rem_next   = k_rank - K_W'(1);
                    i_next     = cnt_m1[IDX_W:1];
                    pos_next   = cnt_m1[IDX_W:1];
                    ld_next    = cnt_m1[IDX_W:1];
                    build_next = 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                mem_req.raddr = ld_reg;
                state_next    = S_LATCH;
            end
            S_LATCH:
            begin
                cur_next      = rdata;
                mem_req.raddr = l_pos[IDX_W-1:0];
                state_next    = (l_pos < lim) ? S_RDR : S_PUT;
            end
            S_RDR:
            begin
                lval_next     = rdata;
                mem_req.raddr = r_pos[IDX_W-1:0];
                state_next    = S_CMP;
            end
            S_CMP:
            begin
                if (best == pos_reg)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = pos_reg;
                    mem_req.wdata = bval;
                    mem_req.raddr = lb_pos[IDX_W-1:0];
                    pos_next      = best;
                    state_next    = (lb_pos < lim) ? S_RDR : S_PUT;
                end
            end
            S_PUT:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = pos_reg;
                mem_req.wdata = cur_reg;
                if (build_reg && (i_reg != '0))
                begin
                    i_next     = i_reg - IDX_W'(1);
                    pos_next   = i_reg - IDX_W'(1);
                    ld_next    = i_reg - IDX_W'(1);
                    state_next = S_LOAD;
                end
                else
                begin
                    build_next = 1'b0;
                    state_next = S_EXT;
                end
            end
            S_EXT:
            begin
                if (rem_reg == '0)
                begin
                    state_next = S_ROOT;
                end
                else
                begin
                    rem_next  = rem_reg - K_W'(1);
                    size_next = size_reg - CNT_W'(1);
                    if (size_reg > CNT_W'(1))
                    begin
                        pos_next   = '0;
                        ld_next    = size_next[IDX_W-1:0];
                        state_next = S_LOAD;
                    end
                end
            end
            S_ROOT:
            begin
                mem_req.raddr = '0;
                state_next    = S_EMIT;
            end
            S_EMIT:
            begin
                done_next   = 1'b1;
                result_next = '{kth_value: rdata, invalid: 1'b0, overflow: ovf_reg};
                count_next  = '0;
                ovf_next    = 1'b0;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            build_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            build_reg <= build_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg   <= size_next;
        rem_reg    <= rem_next;
        i_reg      <= i_next;
        pos_reg    <= pos_next;
        ld_reg     <= ld_next;
        cur_reg    <= cur_next;
        lval_reg   <= lval_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// ===== design/kth_smallest_min_heap_top.sv =====
// ----------------------------------------------------------------------------
// kth_smallest_min_heap_top
// Selects the k-th smallest signed value of a loaded set via a RAM min-heap.
//
//   channel   handshake                 payload
//   input     start & !busy             data   (in_item_t)
//   result    done (one-cycle strobe)   result (result_t)
//   config    cfg_valid & cfg_ready     cfg_data (k_rank)
//
// Loading takes one item per cycle with busy low. An item with last set
// raises busy for the selection: a rank check, then sifts over the single
// RAM read port, each reading the entry, then the children of every entry
// it compares, and writing the entry back. Build sifts from the middle index
// down to the root; each of the k-1 extractions moves the last entry to
// the root and sifts from it, and a final read fetches the root. Rank zero
// or too large ends at the check. The result strobe comes in the first cycle
// with busy low again. Reset clears counts and sets k_rank to 1; the RAM
// needs no clearing. The receiver cannot stall; cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module kth_smallest_min_heap_top
    import ksh_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire in_item_t       data,
    output logic                done,
    output result_t             result,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [K_W-1:0] cfg_data
);

    logic [K_W-1:0]          k_reg;
    mem_req_t                mem_req;
    logic [VAL_W-1:0]        rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= K_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            k_reg <= cfg_data;
        end
    end

    ksh_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .data    (data),
        .k_rank  (k_reg),
        .mem_req (mem_req),
        .rdata   ($signed(rdata)),
        .done    (done),
        .result  (result)
    );

    ksh_ram #(
        .DEPTH (MAX_ELEMENTS),
        .WIDTH (VAL_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (rdata)
    );

endmodule

`default_nettype wire

// ===== tb/sv/kth_smallest_min_heap_top_test.sv =====
// ----------------------------------------------------------------------------
// kth_smallest_min_heap_top_test
// Loads signed data sets, some of them ending in store overflow, under a range
// of k_rank settings and sender gaps. A heap-based selector model predicts
// each result, and the scoreboard checks every result strobe against it.
// ----------------------------------------------------------------------------
module kth_smallest_min_heap_top_test;
    import ksh_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int          SETTLE      = 16;

    class kth_rank_scoreboard;
        logic signed [VAL_W-1:0] slots [MAX_ELEMENTS];
        int unsigned             loaded;
        bit                      dropped;
        logic [K_W-1:0]          rank;
        result_t                 expected_kth [$];
        int unsigned             mismatches;

        function new();
            loaded     = 0;
            dropped    = 1'b0;
            rank       = K_W'(1);
            mismatches = 0;
        endfunction

        function void set_rank(logic [K_W-1:0] r);
            rank = r;
        endfunction

        function void push_down(int unsigned pos, int unsigned size);
            int unsigned             l;
            int unsigned             r;
            int unsigned             best;
            bit                      settled;
            logic signed [VAL_W-1:0] t;
            settled = 1'b0;
            while (!settled)
            begin
                l    = 2 * pos + 1;
                r    = 2 * pos + 2;
                best = pos;
                if (l < size && slots[l] < slots[pos])
                    best = l;
                if (r < size && slots[r] < slots[best])
                    best = r;
                if (best == pos)
                    settled = 1'b1;
                else
                begin
                    t           = slots[pos];
                    slots[pos]  = slots[best];
                    slots[best] = t;
                    pos         = best;
                end
            end
        endfunction

        function void note_input(in_item_t it);
            int unsigned size;
            int unsigned i;
            int unsigned j;
            result_t     exp_res;
            if (loaded < MAX_ELEMENTS)
            begin
                slots[loaded] = it.value;
                loaded++;
            end
            else
                dropped = 1'b1;
            if (!it.last)
                return;
            size              = loaded;
            exp_res.kth_value = '0;
            exp_res.invalid   = (rank == 0) || (rank > size);
            exp_res.overflow  = dropped;
            if (!exp_res.invalid)
            begin
                i = (size - 1) / 2 + 1;
                while (i > 0)
                begin
                    i--;
                    push_down(i, size);
                end
                for (j = 1; j < rank; j++)
                begin
                    if (size > 1)
                    begin
                        slots[0] = slots[size-1];
                        push_down(0, size - 1);
                    end
                    size--;
                end
                exp_res.kth_value = slots[0];
            end
            expected_kth.push_back(exp_res);
            loaded  = 0;
            dropped = 1'b0;
        endfunction

        function void check_result(result_t got);
            result_t exp_res;
            if (expected_kth.size() == 0)
            begin
                $error("result with no item pending: kth_value %0d", $signed(got.kth_value));
                mismatches++;
                return;
            end
            exp_res = expected_kth.pop_front();
            if (got.kth_value !== exp_res.kth_value)
            begin
                $error("kth_value: expected %0d, actual %0d",
                       $signed(exp_res.kth_value), $signed(got.kth_value));
                mismatches++;
            end
            if (got.invalid !== exp_res.invalid)
            begin
                $error("invalid: expected %0b, actual %0b", exp_res.invalid, got.invalid);
                mismatches++;
            end
            if (got.overflow !== exp_res.overflow)
            begin
                $error("overflow: expected %0b, actual %0b", exp_res.overflow, got.overflow);
                mismatches++;
            end
        endfunction
    endclass

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           start     = 1'b0;
    logic           busy;
    in_item_t       data      = '0;
    logic           done;
    result_t        result;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    logic [K_W-1:0] cfg_data  = '0;

    kth_rank_scoreboard      sb;
    int unsigned             cycles = 0;
    int unsigned             sender_idle_pct = 0;
    logic signed [VAL_W-1:0] set_vals [$];

    kth_smallest_min_heap_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .data      (data),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.set_rank(cfg_data);
            if (start && !busy)
                sb.note_input(data);
            if (done)
                sb.check_result(result);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("kth_smallest_min_heap_top regression: fail");
            $finish;
        end
    end

    task automatic send_item(input in_item_t it);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        data  <= it;
        do
            @(posedge clk);
        while (busy);
    endtask

    // last is set on the final entry of set_vals
    task automatic send_set();
        int i;
        for (i = 0; i < set_vals.size(); i++)
            send_item(in_item_t'{value: set_vals[i], last: (i == set_vals.size() - 1)});
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (sb.expected_kth.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_rank(input int r);
        cfg_valid <= 1'b1;
        cfg_data  <= K_W'(r);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value(input int mode);
        logic [VAL_W-1:0] v;
        case (mode)
            0: v = $urandom;
            1: v = $urandom_range(3) - 2;
            default:
            begin
                case ($urandom_range(5))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'h0000_0000;
                    3: v = 32'hFFFF_FFFF;
                    4: v = 32'h0000_0001;
                    default: v = $urandom;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic int pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(1, 12);
        else if (r < 95)
            return $urandom_range(13, 64);
        return $urandom_range(65, 200);
    endfunction

    int phase_idle [12] = '{0, 48, 7, 0, 48, 7, 0, 48, 7, 0, 48, 7};
    int phase_rank [12] = '{1, 3, 0, 6, 2047, 12, 2, 1024, 4, 8, -1, -1};

    initial
    begin
        int p;
        int n;
        int i;
        int mode;
        int items_left;

        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset rank of one, extremes, ties, bad ranks
        set_vals = '{32'sh7FFF_FFFF};
        send_set();
        set_vals = '{32'sd0, 32'sh8000_0000, -32'sd1, 32'sd5};
        send_set();
        wait_idle();
        write_rank(0);
        set_vals = '{32'sd3, 32'sd4};
        send_set();
        wait_idle();
        write_rank(3);
        set_vals = '{32'sd2, 32'sd2, 32'sd1, 32'sd2, 32'sd1};
        send_set();
        wait_idle();
        write_rank(6);
        set_vals = '{32'sd9, -32'sd9, 32'sd1, -32'sd1, 32'sd0};
        send_set();
        wait_idle();
        write_rank(5);
        send_set();
        wait_idle();
        write_rank(2047);
        set_vals = '{32'sd1};
        send_set();
        wait_idle();
        write_rank(2);
        set_vals = '{-32'sd1, -32'sd1};
        send_set();
        wait_idle();

        // random sets, back to back within a phase
        for (p = 0; p < 12; p++)
        begin
            sender_idle_pct = phase_idle[p];
            write_rank((phase_rank[p] < 0) ? $urandom_range(1, 16) : phase_rank[p]);
            items_left = 25;
            while (items_left > 0)
            begin
                n    = pick_size();
                mode = $urandom_range(2);
                set_vals.delete();
                for (i = 0; i < n; i++)
                    set_vals.push_back(pick_value(mode));
                send_set();
                items_left -= n;
            end
            wait_idle();
        end

        // full store at the largest rank, then overflow with the marked item dropped
        sender_idle_pct = 7;
        write_rank(1024);
        set_vals.delete();
        for (i = 0; i < MAX_ELEMENTS + 2; i++)
            set_vals.push_back(pick_value(i % 3));
        send_set();
        wait_idle();

        // overflow flag must clear for the next set
        write_rank(1);
        set_vals = '{32'sh8000_0000, 32'sh7FFF_FFFF};
        send_set();
        wait_idle();

        if (sb.mismatches == 0 && sb.expected_kth.size() == 0)
            $display("kth_smallest_min_heap_top regression: pass");
        else
            $display("kth_smallest_min_heap_top regression: fail");
        $finish;
    end

endmodule
